FILE: sv/cmfe_pkg.sv
// ----------------------------------------------------------------------------
// cmfe_pkg
// Shared types and constants for the color model fill and byte encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cmfe_pkg;

  localparam int unsigned CH_W     = 17;
  localparam int unsigned BYTE_W   = 8;
  localparam logic [CH_W-1:0] ONE_Q16 = 17'd65536;

  // Pipeline latencies of the lanes.
  localparam int unsigned DIV_LAT  = 17;
  localparam int unsigned GRAY_LAT = 8;

  // Output model codes.
  localparam logic [1:0] MODEL_RGB   = 2'd0;
  localparam logic [1:0] MODEL_CMYK  = 2'd1;
  localparam logic [1:0] MODEL_GRAY  = 2'd2;
  localparam logic [1:0] MODEL_SPARE = 2'd3;

  // Valid model mask bits.
  localparam int unsigned MASK_RGB  = 0;
  localparam int unsigned MASK_CMYK = 1;
  localparam int unsigned MASK_GRAY = 2;

  typedef struct packed {
    logic [2:0]      valid_models;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] cyan;
    logic [CH_W-1:0] magenta;
    logic [CH_W-1:0] yellow;
    logic [CH_W-1:0] black;
    logic [CH_W-1:0] gray;
  } cmfe_item_t;

  typedef struct packed {
    logic [CH_W-1:0]   channel_value;
    logic [BYTE_W-1:0] channel_byte;
    logic              last_channel;
  } cmfe_result_t;

  // One color's worth of results, first channel in slot 0.
  typedef struct packed {
    logic [2:0]                  count;
    logic [3:0][CH_W-1:0]        value;
    logic [3:0][BYTE_W-1:0]      bytes;
  } cmfe_burst_t;

endpackage

`default_nettype wire

FILE: sv/cmfe_div_lane.sv
// ----------------------------------------------------------------------------
// cmfe_div_lane
// Pipelined restoring divider: q = (a << 16) / d for a <= d, one bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmfe_div_lane
  import cmfe_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [CH_W-1:0] a,
  input  wire logic [CH_W-1:0] d,
  output logic      [CH_W-1:0] q
);

  logic [CH_W-1:0] rem   [1:DIV_LAT];
  logic [CH_W-1:0] quo   [1:DIV_LAT];
  logic [CH_W-1:0] dvs   [1:DIV_LAT];
  logic [CH_W:0]   shl   [2:DIV_LAT];
  logic            ge    [2:DIV_LAT];
  logic            top_bit;

  assign top_bit = (a >= d);

  always_comb begin
    for (int j = 2; j <= DIV_LAT; j++) begin
      shl[j] = {rem[j-1], 1'b0};
      ge[j]  = (shl[j] >= {1'b0, dvs[j-1]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[1] <= top_bit ? (a - d) : a;
      quo[1] <= {{(CH_W-1){1'b0}}, top_bit};
      dvs[1] <= d;
      for (int j = 2; j <= DIV_LAT; j++) begin
        rem[j] <= ge[j] ? CH_W'(shl[j] - {1'b0, dvs[j-1]}) : shl[j][CH_W-1:0];
        quo[j] <= {quo[j-1][CH_W-2:0], ge[j]};
        dvs[j] <= dvs[j-1];
      end
    end
  end

  assign q = quo[DIV_LAT];

endmodule

`default_nettype wire

FILE: sv/cmfe_gray_lane.sv
// ----------------------------------------------------------------------------
// cmfe_gray_lane
// Luma and sRGB gamma: weighted sum, table lookup with interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmfe_gray_lane
  import cmfe_pkg::*;
#(
  parameter int unsigned GAMMA_TABLE_ENTRIES = 1024
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [CH_W-1:0] red,
  input  wire logic [CH_W-1:0] green,
  input  wire logic [CH_W-1:0] blue,
  output logic      [CH_W-1:0] gray
);

  localparam int unsigned N  = GAMMA_TABLE_ENTRIES;
  localparam int unsigned IW = $clog2(N + 1);
  localparam int unsigned PW = CH_W + IW;

  typedef logic [CH_W-1:0] gtab_t [0:N];

  // floor(65536 * (i/n)^(5/12)), exact: largest t with t^12 n^5 <= i^5 2^192.
  function automatic logic [CH_W-1:0] gamma_entry(input int unsigned i,
                                                  input int unsigned n);
    logic [319:0] rhs;
    logic [319:0] lhs;
    logic [17:0]  lo;
    logic [17:0]  hi;
    logic [17:0]  mid;
    rhs = 320'd1 << 192;
    for (int k = 0; k < 5; k++) rhs = rhs * 320'(i);
    lo = 18'd0;
    hi = 18'd65536;
    for (int s = 0; s < 18; s++) begin
      if (lo < hi) begin
        mid = (lo + hi + 18'd1) >> 1;
        lhs = 320'd1;
        for (int k = 0; k < 12; k++) lhs = lhs * 320'(mid);
        for (int k = 0; k < 5; k++) lhs = lhs * 320'(n);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 18'd1;
      end
    end
    return lo[CH_W-1:0];
  endfunction

  function automatic gtab_t build_tab();
    gtab_t t;
    for (int i = 0; i <= N; i++) t[i] = gamma_entry(i, N);
    return t;
  endfunction

  localparam gtab_t GTAB = build_tab();

  logic [31:0]     pr, pg, pb;
  logic [CH_W-1:0] lum;
  logic [PW-1:0]   pos;
  logic [CH_W-1:0] lin3, lin4, lin5, lin6, lin7;
  logic            small3, small4, small5, small6, small7;
  logic [CH_W-1:0] t0, t1, t0_5;
  logic [15:0]     fr;
  logic [CH_W-1:0] dq;
  logic [CH_W-1:0] p;
  logic [17:0]     mh;

  logic [32:0]     sum;
  logic [27:0]     lin_prod;
  logic            over;
  logic [IW-1:0]   idx;
  logic [IW-1:0]   addr0, addr1;
  logic [32:0]     dprod;
  logic [17:0]     psum;
  logic [33:0]     mprod;
  logic [17:0]     wdiff;
  logic [CH_W-1:0] w_next;

  always_comb begin
    sum      = 33'(pr) + 33'(pg) + 33'(pb);
    lin_prod = 28'(lum[7:0]) * 28'd846725;
    over     = (pos[PW-1:16] >= (IW+1)'(N));
    idx      = pos[16 +: IW];
    addr0    = over ? IW'(N) : idx;
    addr1    = over ? IW'(N) : IW'(idx + IW'(1));
    dprod    = 33'(t1 - t0) * 33'(fr);
    psum     = 18'(t0_5) + 18'(dq);
    mprod    = 34'(p) * 34'd69140;
    wdiff    = mh - 18'd3604;
    if (small7) begin
      w_next = lin7;
    end else if (mh < 18'd3604) begin
      w_next = '0;
    end else if (wdiff > 18'(ONE_Q16)) begin
      w_next = ONE_Q16;
    end else begin
      w_next = wdiff[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr     <= 32'(red)   * 32'd13933;
      pg     <= 32'(green) * 32'd46871;
      pb     <= 32'(blue)  * 32'd4732;
      lum    <= sum[32:16];
      pos    <= PW'(lum) * PW'(N);
      lin3   <= CH_W'(lin_prod[27:16]);
      small3 <= (lum <= CH_W'(205));
      t0     <= GTAB[addr0];
      t1     <= GTAB[addr1];
      fr     <= over ? 16'd0 : pos[15:0];
      lin4   <= lin3;
      small4 <= small3;
      dq     <= dprod[32:16];
      t0_5   <= t0;
      lin5   <= lin4;
      small5 <= small4;
      p      <= psum[CH_W-1:0];
      lin6   <= lin5;
      small6 <= small5;
      mh     <= mprod[33:16];
      lin7   <= lin6;
      small7 <= small6;
      gray   <= w_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/cmfe_emit.sv
// ----------------------------------------------------------------------------
// cmfe_emit
// Output register: hold one color's channels, hand out one a cycle on ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cmfe_emit
  import cmfe_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         load,
  input  wire cmfe_burst_t  burst,
  output logic              can_load,
  output logic              result_valid,
  input  wire logic         result_ready,
  output cmfe_result_t      result
);

  logic [2:0]             count;
  logic [3:0][CH_W-1:0]   value;
  logic [3:0][BYTE_W-1:0] bytes;

  assign result_valid = (count != 3'd0);
  assign can_load     = !result_valid || (result_ready && count == 3'd1);

  assign result.channel_value = value[0];
  assign result.channel_byte  = bytes[0];
  assign result.last_channel  = (count == 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else if (load && can_load) begin
      count <= burst.count;
    end else if (result_valid && result_ready) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      value <= burst.value;
      bytes <= burst.bytes;
    end else if (result_valid && result_ready) begin
      for (int i = 0; i < 3; i++) begin
        value[i] <= value[i+1];
        bytes[i] <= bytes[i+1];
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/color_model_fill_and_encode.sv
// ----------------------------------------------------------------------------
// color_model_fill_and_encode
// Fill missing RGB / CMYK / gray models of a color and emit one output model
// as Q16 channel values and bytes.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item): one color per request, with a
//   mask of valid models and all eight Q16 channels (values above 1.0 are
//   saturated). result channel (result_valid/result_ready/result): one
//   request per output channel, last_channel marks the final one of a color.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): output model, 0 RGB (3
//   results), 1 or 3 CMYK (4 results), 2 gray (1 result); write while idle.
// An item passes the pipeline stages, then the output register, before its
//   first result request. Throughput is set by the output register, which
//   emits one channel a cycle while result_ready is high; the 21-stage
//   pipeline (three divider lanes, gamma lane) takes a new color every
//   cycle unless held. If the output register cannot take a color, the whole
//   pipeline holds once its last stage is full; item_ready drops only then.
// Reset clears the pipeline valid bits, the output register and sets the
//   output model to RGB.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module color_model_fill_and_encode
  import cmfe_pkg::*;
#(
  parameter int unsigned GAMMA_TABLE_ENTRIES = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output logic              item_ready,
  input  wire cmfe_item_t   item,
  output logic              result_valid,
  input  wire logic         result_ready,
  output cmfe_result_t      result,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_data
);

  // Stage numbering: stage 1 holds the saturated item, stage 4 the CMYK
  // prep, stage DEPTH the aligned outputs of all lanes.
  localparam int unsigned DEPTH = 4 + DIV_LAT;
  localparam int unsigned W_DLY = DEPTH - (3 + GRAY_LAT);

  typedef struct packed {
    logic [2:0]           mask;
    logic [2:0][CH_W-1:0] rgb;
    logic [3:0][CH_W-1:0] cmyk_in;
    logic [CH_W-1:0]      w_in;
    logic [CH_W-1:0]      kk;
  } cmfe_carry_t;

  logic [1:0]       model_sel;
  logic [DEPTH:1]   vld;
  logic             en;
  logic             can_load;

  cmfe_item_t       s1, s2, s3;
  logic [2:0][CH_W-1:0] cm_rgb;
  logic [2:0][CH_W-1:0] rgb3;
  cmfe_carry_t      s4;
  logic [2:0][CH_W-1:0] diff4;
  cmfe_carry_t      dly [5:DEPTH];
  logic [CH_W-1:0]  w_dly [1:W_DLY];

  cmfe_item_t       sat_item;
  logic [2:0][CH_W-1:0] rgb_sel;
  logic [CH_W-1:0]  c3, m3, y3, k3;
  logic [2:0][CH_W-1:0] div_q;
  logic [CH_W-1:0]  w_calc;
  cmfe_burst_t      burst;

  function automatic logic [CH_W-1:0] sat1(input logic [CH_W-1:0] x);
    return (x > ONE_Q16) ? ONE_Q16 : x;
  endfunction

  function automatic logic [CH_W-1:0] inv_mul(input logic [CH_W-1:0] x,
                                              input logic [CH_W-1:0] k);
    logic [33:0] pr;
    pr = 34'(ONE_Q16 - x) * 34'(ONE_Q16 - k);
    return pr[32:16];
  endfunction

  function automatic logic [BYTE_W-1:0] to_byte(input logic [CH_W-1:0] x);
    logic [24:0] t;
    t = {x, 8'd0} - 25'(x);
    return t[23:16];
  endfunction

  // Configuration: always ready; user must write only while idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      model_sel <= MODEL_RGB;
    end else if (cfg_valid) begin
      model_sel <= cfg_data;
    end
  end

  // Advance the pipeline unless the last stage is full and cannot unload.
  assign en         = !vld[DEPTH] || can_load;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-1:1], item_valid};
    end
  end

  // Saturate every channel to 1.0 on the way in.
  always_comb begin
    sat_item              = item;
    sat_item.valid_models = item.valid_models;
    sat_item.red          = sat1(item.red);
    sat_item.green        = sat1(item.green);
    sat_item.blue         = sat1(item.blue);
    sat_item.cyan         = sat1(item.cyan);
    sat_item.magenta      = sat1(item.magenta);
    sat_item.yellow       = sat1(item.yellow);
    sat_item.black        = sat1(item.black);
    sat_item.gray         = sat1(item.gray);
  end

  // RGB source: given wins; else gray overrides CMYK; else CMYK; else as given.
  always_comb begin
    if (s2.valid_models[MASK_RGB]) begin
      rgb_sel = {s2.blue, s2.green, s2.red};
    end else if (s2.valid_models[MASK_GRAY]) begin
      rgb_sel = {s2.gray, s2.gray, s2.gray};
    end else if (s2.valid_models[MASK_CMYK]) begin
      rgb_sel = cm_rgb;
    end else begin
      rgb_sel = {s2.blue, s2.green, s2.red};
    end
  end

  // K = min of the three inverses.
  always_comb begin
    c3 = ONE_Q16 - rgb3[0];
    m3 = ONE_Q16 - rgb3[1];
    y3 = ONE_Q16 - rgb3[2];
    k3 = c3;
    if (k3 > m3) k3 = m3;
    if (k3 > y3) k3 = y3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1        <= sat_item;
      s2        <= s1;
      cm_rgb[0] <= inv_mul(s1.cyan,    s1.black);
      cm_rgb[1] <= inv_mul(s1.magenta, s1.black);
      cm_rgb[2] <= inv_mul(s1.yellow,  s1.black);
      s3        <= s2;
      rgb3      <= rgb_sel;
      s4.mask    <= s3.valid_models;
      s4.rgb     <= rgb3;
      s4.cmyk_in <= {s3.black, s3.yellow, s3.magenta, s3.cyan};
      s4.w_in    <= s3.gray;
      s4.kk      <= k3;
      diff4[0]   <= c3 - k3;
      diff4[1]   <= m3 - k3;
      diff4[2]   <= y3 - k3;
      dly[5]     <= s4;
      for (int j = 6; j <= DEPTH; j++) dly[j] <= dly[j-1];
      w_dly[1]   <= w_calc;
      for (int j = 2; j <= W_DLY; j++) w_dly[j] <= w_dly[j-1];
    end
  end

  // Divider lanes: C, M, Y = (x - K) / (1 - K).
  for (genvar l = 0; l < 3; l++) begin : g_div
    cmfe_div_lane u_div (
      .clk (clk),
      .en  (en),
      .a   (diff4[l]),
      .d   (ONE_Q16 - s4.kk),
      .q   (div_q[l])
    );
  end

  // Gamma lane works on the chosen RGB.
  cmfe_gray_lane #(
    .GAMMA_TABLE_ENTRIES (GAMMA_TABLE_ENTRIES)
  ) u_gray (
    .clk   (clk),
    .en    (en),
    .red   (rgb3[0]),
    .green (rgb3[1]),
    .blue  (rgb3[2]),
    .gray  (w_calc)
  );

  // Merge: pick filled or given values, then the output model's channels.
  always_comb begin
    logic                 has_r;
    logic                 has_c;
    logic                 has_g;
    logic [CH_W-1:0]      gray_v;
    logic [3:0][CH_W-1:0] cmyk_v;
    logic                 kfull;
    has_r  = dly[DEPTH].mask[MASK_RGB];
    has_c  = dly[DEPTH].mask[MASK_CMYK];
    has_g  = dly[DEPTH].mask[MASK_GRAY];
    kfull  = (dly[DEPTH].kk == ONE_Q16);
    gray_v = (has_g || !(has_r || has_c)) ? dly[DEPTH].w_in : w_dly[W_DLY];
    if (!has_c && (has_r || has_g)) begin
      cmyk_v[0] = kfull ? '0 : div_q[0];
      cmyk_v[1] = kfull ? '0 : div_q[1];
      cmyk_v[2] = kfull ? '0 : div_q[2];
      cmyk_v[3] = dly[DEPTH].kk;
    end else begin
      cmyk_v = dly[DEPTH].cmyk_in;
    end
    burst = '0;
    unique case (model_sel)
      MODEL_RGB: begin
        burst.count    = 3'd3;
        burst.value[0] = dly[DEPTH].rgb[0];
        burst.value[1] = dly[DEPTH].rgb[1];
        burst.value[2] = dly[DEPTH].rgb[2];
      end
      MODEL_GRAY: begin
        burst.count    = 3'd1;
        burst.value[0] = gray_v;
      end
      MODEL_CMYK, MODEL_SPARE: begin
        burst.count = 3'd4;
        burst.value = cmyk_v;
      end
      default: begin
        burst.count = 3'd4;
        burst.value = cmyk_v;
      end
    endcase
    for (int i = 0; i < 4; i++) burst.bytes[i] = to_byte(burst.value[i]);
  end

  cmfe_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (vld[DEPTH]),
    .burst        (burst),
    .can_load     (can_load),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: tb/color_model_fill_and_encode_test.sv
// ----------------------------------------------------------------------------
// color_model_fill_and_encode_test
// Self-checking bench for the color fill and byte encoder: drives colors with
// random masks and channels, predicts the filled channels of the selected
// output model and checks every result request in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module color_model_fill_and_encode_test;
  import cmfe_pkg::*;

  localparam int unsigned GAMMA_N = 1024;

  // Predicts the results of each accepted color and checks them in order.
  class color_scoreboard;
    int unsigned gamma_lut[GAMMA_N+1];
    cmfe_result_t pending_q[$];
    int errors;

    function new();
      bit [299:0] lhs, rhs;
      int unsigned lo, hi, mid;
      errors = 0;
      // Build x^(5/12) exactly: largest t with t^12 * N^5 <= i^5 * 2^192.
      for (int i = 0; i <= GAMMA_N; i++) begin
        rhs = 300'd1 << 192;
        for (int k = 0; k < 5; k++) rhs = rhs * i;
        lo = 0;
        hi = 65536;
        while (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          lhs = 300'd1;
          for (int k = 0; k < 12; k++) lhs = lhs * mid;
          for (int k = 0; k < 5; k++) lhs = lhs * GAMMA_N;
          if (lhs <= rhs) lo = mid;
          else hi = mid - 1;
        end
        gamma_lut[i] = lo;
      end
    endfunction

    function longint unsigned clip_one(longint unsigned v);
      return (v > 65536) ? 65536 : v;
    endfunction

    function longint unsigned luma_to_gray(longint unsigned r, longint unsigned g,
                                           longint unsigned b);
      longint unsigned lum, pos, idx, fr, p;
      longint w;
      lum = (13933 * r + 46871 * g + 4732 * b) >> 16;
      if (lum <= 205) return clip_one((lum * 846725) >> 16);
      pos = lum * GAMMA_N;
      idx = pos >> 16;
      fr  = pos & 16'hFFFF;
      if (idx >= GAMMA_N) p = gamma_lut[GAMMA_N];
      else p = gamma_lut[idx] + (((gamma_lut[idx+1] - gamma_lut[idx]) * fr) >> 16);
      w = longint'((69140 * p) >> 16) - 3604;
      if (w < 0) w = 0;
      return clip_one(w);
    endfunction

    // ch: 0 R, 1 G, 2 B, 3 C, 4 M, 5 Y, 6 K, 7 W
    function void fill_cmyk(ref longint unsigned ch[8]);
      longint unsigned c, m, y, k;
      c = 65536 - ch[0];
      m = 65536 - ch[1];
      y = 65536 - ch[2];
      k = c;
      if (k > m) k = m;
      if (k > y) k = y;
      ch[6] = k;
      if (k == 65536) begin
        ch[3] = 0; ch[4] = 0; ch[5] = 0;
      end else begin
        ch[3] = clip_one(((c - k) << 16) / (65536 - k));
        ch[4] = clip_one(((m - k) << 16) / (65536 - k));
        ch[5] = clip_one(((y - k) << 16) / (65536 - k));
      end
    endfunction

    // Note an accepted color: fill its models and queue the expected channels.
    function void note_color(cmfe_item_t it, logic [1:0] model);
      longint unsigned ch[8];
      int sel[4];
      int n;
      bit has_rgb, has_cmyk, has_gray;
      cmfe_result_t r;
      longint unsigned byte_v;
      has_rgb  = it.valid_models[MASK_RGB];
      has_cmyk = it.valid_models[MASK_CMYK];
      has_gray = it.valid_models[MASK_GRAY];
      ch[0] = clip_one(64'(it.red));     ch[1] = clip_one(64'(it.green));
      ch[2] = clip_one(64'(it.blue));    ch[3] = clip_one(64'(it.cyan));
      ch[4] = clip_one(64'(it.magenta)); ch[5] = clip_one(64'(it.yellow));
      ch[6] = clip_one(64'(it.black));   ch[7] = clip_one(64'(it.gray));
      if (has_rgb) begin
        if (!has_cmyk) fill_cmyk(ch);
        if (!has_gray) ch[7] = luma_to_gray(ch[0], ch[1], ch[2]);
      end
      if (has_cmyk) begin
        if (!has_rgb) begin
          ch[0] = ((65536 - ch[3]) * (65536 - ch[6])) >> 16;
          ch[1] = ((65536 - ch[4]) * (65536 - ch[6])) >> 16;
          ch[2] = ((65536 - ch[5]) * (65536 - ch[6])) >> 16;
        end
        if (!has_gray) ch[7] = luma_to_gray(ch[0], ch[1], ch[2]);
      end
      if (has_gray) begin
        if (!has_rgb) begin
          ch[0] = ch[7]; ch[1] = ch[7]; ch[2] = ch[7];
        end
        if (!has_cmyk) fill_cmyk(ch);
      end
      // Bit 0 wins, so the spare code behaves as CMYK.
      if (model[0]) begin
        n = 4; sel = '{3, 4, 5, 6};
      end else if (model[1]) begin
        n = 1; sel = '{7, 0, 0, 0};
      end else begin
        n = 3; sel = '{0, 1, 2, 0};
      end
      for (int k = 0; k < n; k++) begin
        byte_v = (255 * ch[sel[k]]) >> 16;
        if (byte_v > 255) byte_v = 255;
        r.channel_value = CH_W'(ch[sel[k]]);
        r.channel_byte  = BYTE_W'(byte_v);
        r.last_channel  = (k == n - 1);
        pending_q.push_back(r);
      end
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(cmfe_result_t r);
      cmfe_result_t e;
      if (pending_q.size() == 0) begin
        report("unexpected result, value", 64'(r.channel_value), 0);
        return;
      end
      e = pending_q.pop_front();
      if (r.channel_value !== e.channel_value)
        report("channel_value", 64'(r.channel_value), 64'(e.channel_value));
      if (r.channel_byte !== e.channel_byte)
        report("channel_byte", 64'(r.channel_byte), 64'(e.channel_byte));
      if (r.last_channel !== e.last_channel)
        report("last_channel", 64'(r.last_channel), 64'(e.last_channel));
    endtask
  endclass

  logic         clk;
  logic         rst;
  logic         item_valid;
  logic         item_ready;
  cmfe_item_t   item;
  logic         result_valid;
  logic         result_ready;
  cmfe_result_t result;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_data;

  color_scoreboard board;
  logic [1:0] out_model;   // model in force, mirrors the last register write
  bit         calm;        // no idling on either side
  int         hold_off;    // receiver hold-off cycles still to go

  color_model_fill_and_encode #(
    .GAMMA_TABLE_ENTRIES(GAMMA_N)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: check each accepted result, then pick next cycle's ready.
  // Stall in bursts, or hold off for a long stretch when asked.
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) board.check_result(result);
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off--;
      result_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Offer one color, with an idle burst first now and then; hold until taken.
  task automatic send_color(cmfe_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    board.note_color(it, out_model);
  endtask

  // Drop valid and wait until every expected channel has arrived.
  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_model(logic [1:0] m);
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    out_model = m;
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ONE_Q16;
      2: return CH_W'($urandom_range(0, 2**CH_W - 1));  // may exceed 1.0
      3: return CH_W'($urandom_range(0, 400));          // dark end of the gamma curve
      default: return CH_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic cmfe_item_t random_color();
    cmfe_item_t it;
    it.valid_models = 3'($urandom_range(0, 7));
    it.red     = pick_channel();
    it.green   = pick_channel();
    it.blue    = pick_channel();
    it.cyan    = pick_channel();
    it.magenta = pick_channel();
    it.yellow  = pick_channel();
    it.black   = pick_channel();
    it.gray    = pick_channel();
    return it;
  endfunction

  function automatic cmfe_item_t flat_color(logic [2:0] mask, logic [CH_W-1:0] v);
    cmfe_item_t it;
    it.valid_models = mask;
    it.red = v; it.green = v; it.blue = v; it.cyan = v;
    it.magenta = v; it.yellow = v; it.black = v; it.gray = v;
    return it;
  endfunction

  cmfe_item_t it;
  logic [1:0] phase_models[6] = '{MODEL_CMYK, MODEL_GRAY, MODEL_SPARE,
                                  MODEL_RGB, MODEL_CMYK, MODEL_RGB};

  initial begin
    board      = new();
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    cfg_valid  = 1'b0;
    cfg_data   = MODEL_RGB;
    out_model  = MODEL_RGB;
    calm       = 1'b0;
    hold_off   = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed colors under the reset model (RGB): every mask at the extremes,
    // black from CMYK (K at 1.0), the linear gray segment and saturation.
    for (int m = 0; m < 8; m++) begin
      send_color(flat_color(3'(m), '0));
      send_color(flat_color(3'(m), ONE_Q16));
    end
    send_color(flat_color(3'b001, '1));
    send_color(flat_color(3'b110, 17'd70000));
    it = flat_color(3'b001, 17'd100);
    send_color(it);
    it = flat_color(3'b010, '0);
    it.black = ONE_Q16;
    send_color(it);
    it = flat_color(3'b100, 17'd150);
    send_color(it);
    drain();

    // Random phases across all output models; the last one runs without idling.
    foreach (phase_models[p]) begin
      write_model(phase_models[p]);
      calm = (p == 5);
      for (int n = 0; n < 45; n++) begin
        // Stall the receiver long enough to back the pipeline up to the input.
        if (p == 1 && n == 5) hold_off = 120;
        send_color(random_color());
      end
      drain();
    end

    if (board.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
sv/cmfe_pkg.sv
sv/cmfe_div_lane.sv
sv/cmfe_gray_lane.sv
sv/cmfe_emit.sv
sv/color_model_fill_and_encode.sv
tb/color_model_fill_and_encode_test.sv
